[rtl/pcat_pkg.sv]
`timescale 1ns / 1ps
// constants shared by the pitch class activity tracker modules
// no dependencies

package pcat_pkg;

  localparam int unsigned NCLASS = 12;
  localparam int unsigned CLS_W = 4;
  localparam logic [CLS_W-1:0] LAST_CLS = 4'd11;

  // activity is unsigned Q11.16, clamped at 1024.0
  localparam int unsigned ACT_W = 27;
  localparam logic [ACT_W-1:0] ACT_MAX = 27'd67108864;

  // decay factor in Q1.16, built from powers of e^(-1/2000) in Q0.32
  localparam int unsigned F_W = 17;
  localparam logic [F_W-1:0] F_ONE = 17'd65536;
  localparam int unsigned DT_BITS = 15;
  localparam logic [31:0] DT_LIMIT = 32'd32768;
  localparam logic [31:0] DECAY_BASE = 32'd4292820349;
  localparam logic [31:0] HALF_Q32 = 32'h8000_0000;
  localparam logic [15:0] HALF_Q16 = 16'h8000;

  localparam int unsigned LVL_W = 8;
  localparam int unsigned SHARE_W = 16;
  localparam logic [SHARE_W-1:0] SHARE_MAX = 16'hFFFF;

  localparam logic [15:0] INTERVAL_RST = 16'd100;

endpackage

[rtl/pcat_share_div.sv]
`timescale 1ns / 1ps
// radix-2 restoring divider for the count share, one quotient bit per cycle
// depends on pcat_pkg

module pcat_share_div #(
  parameter int unsigned W = 36
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [W-1:0]                 num,
  input  logic [W-1:0]                 den,
  output logic                         done,
  output logic [pcat_pkg::SHARE_W-1:0] quo
);
  import pcat_pkg::*;

  localparam int unsigned STEP_W = $clog2(SHARE_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SHARE_W - 1);

  logic              busy_r;
  logic              done_r;
  logic              sat_r;
  logic [STEP_W-1:0] step_r;
  logic [W-1:0]      rem_r;
  logic [W-1:0]      den_r;
  logic [SHARE_W-1:0] q_r;
  logic [W:0]        rem2;
  logic              take;

  assign rem2 = {rem_r, 1'b0};
  assign take = rem2 >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      den_r <= den;
      sat_r <= num >= den;
      q_r   <= '0;
    end else if (busy_r) begin
      if (take) begin
        rem_r <= W'(rem2 - {1'b0, den_r});
        q_r   <= {q_r[SHARE_W-2:0], 1'b1};
      end else begin
        rem_r <= rem2[W-1:0];
        q_r   <= {q_r[SHARE_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = sat_r ? SHARE_MAX : q_r;

endmodule

[rtl/pitch_class_activity_tracker.sv]
`timescale 1ns / 1ps
// pitch class activity tracker top level: per-class state memory and sequencer
// depends on pcat_pkg and pcat_share_div
//
// Input channel (in_valid/in_ready) takes note events (in_op = 0) and time
// ticks (in_op = 1). A note produces no result; it is a read of the class entry
// followed by a write in the next cycle.
// A tick produces twelve results on out_valid/out_ready, classes 0..11 in
// order, out_last on the twelfth. A tick runs in three parts: the decay
// factor (15 squaring steps, each a multiply phase then a rounding phase, on
// one 33x32 and one 32x32 multiplier, then a final rounding step) overlapped
// with a sweep of the state memory over all twelve classes that sums the
// counts, then per class one memory read, one decay multiply and a 16-step
// share division.
// in_ready is high only while no item is in progress. A result waits in an
// output register; while it waits the next class is already worked on, and
// the block holds before loading the following result if out_ready stays low.
// Reset (rst_n low, synchronous) clears every entry through per-entry valid
// bits at once, marks that no tick has been seen and sets the interval to 100.
// cfg_wr_en writes the inference interval in ms; write it only while idle.

module pitch_class_activity_tracker #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [6:0]  in_midi_note,
  input  logic [6:0]  in_velocity,
  input  logic [31:0] in_now_ms,

  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pcat_pkg::CLS_W-1:0]   out_pitch_class,
  output logic [pcat_pkg::LVL_W-1:0]   out_activity_level,
  output logic [pcat_pkg::SHARE_W-1:0] out_hist_share,
  output logic                         out_hist_valid,
  output logic                         out_last
);
  import pcat_pkg::*;

  localparam int unsigned SUM_W = COUNT_BITS + 4;
  localparam int unsigned TOT_W = (SUM_W > 64) ? 64 : SUM_W;
  localparam int unsigned MEM_W = COUNT_BITS + ACT_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NOTE = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_PREP = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  localparam logic [1:0] FP_MUL = 2'd0;
  localparam logic [1:0] FP_RND = 2'd1;
  localparam logic [1:0] FP_FIN = 2'd2;

  localparam logic [3:0] LAST_DT_BIT = 4'(DT_BITS - 1);

  function automatic logic [CLS_W-1:0] note_class(input logic [6:0] note);
    logic [6:0] v;
    v = note;
    if (v >= 7'd96) v = v - 7'd96;
    if (v >= 7'd48) v = v - 7'd48;
    if (v >= 7'd24) v = v - 7'd24;
    if (v >= 7'd12) v = v - 7'd12;
    return v[CLS_W-1:0];
  endfunction

  // control
  logic [2:0]       state_r, state_nxt;
  logic [CLS_W-1:0] cls_r;
  logic [15:0]      interval_r;
  logic             seen_r;
  logic [31:0]      last_decay_r;
  logic [31:0]      last_upd_r;
  logic             elapsed_r;
  logic             hist_valid_r;
  logic             ovf_r;
  logic             sum_tag_r;

  // note operands
  logic [CLS_W-1:0] pc_r;
  logic [6:0]       vel_r;

  // state memory with per-entry valid bits
  logic [MEM_W-1:0] mem_r [NCLASS];
  logic [NCLASS-1:0] vld_r;
  logic [MEM_W-1:0] mem_q_r;
  logic             mem_qv_r;
  logic [CLS_W-1:0] mem_raddr;
  logic             mem_we;
  logic [CLS_W-1:0] mem_waddr;
  logic [MEM_W-1:0] mem_wdata;
  logic [MEM_W-1:0] entry;
  logic [COUNT_BITS-1:0] ent_cnt;
  logic [ACT_W-1:0] ent_act;

  // decay factor sequencer
  logic             fs_busy_r;
  logic [1:0]       fs_ph_r;
  logic [3:0]       fb_r;
  logic [DT_BITS-1:0] dt_r;
  logic [32:0]      acc_r;
  logic [31:0]      pw_r;
  logic [64:0]      pa_r;
  logic [63:0]      pp_r;
  logic [F_W-1:0]   f_r;
  logic             f_done_r;
  logic [31:0]      dt;

  // per-class datapath
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum4_r;
  logic [TOT_W-1:0] total_r;
  logic [TOT_W-1:0] total;
  logic             ovf;
  logic [COUNT_BITS-1:0] cnt_keep_r;
  logic [ACT_W+F_W-1:0]  act_prod_r;
  logic [ACT_W-1:0] act_new;
  logic [ACT_W+7:0] lvl_prod;
  logic [LVL_W-1:0] lvl_r;
  logic             wb_pend_r;
  logic [COUNT_BITS-1:0] div_cnt;
  logic             div_start;
  logic             div_done;
  logic [SHARE_W-1:0] div_quo;

  // note update
  logic [COUNT_BITS-1:0] note_cnt;
  logic [ACT_W:0]   note_sum;
  logic [ACT_W-1:0] note_act;

  logic in_xfer;
  logic out_load;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign dt       = in_now_ms - last_decay_r;

  // memory view: an entry never written reads as zero
  assign entry   = mem_qv_r ? mem_q_r : '0;
  assign ent_cnt = entry[MEM_W-1:ACT_W];
  assign ent_act = entry[ACT_W-1:0];

  assign note_cnt = (ent_cnt == CNT_MAX) ? ent_cnt : ent_cnt + 1'b1;
  assign note_sum = {1'b0, ent_act} + {1'b0, vel_r, 16'b0};
  assign note_act = (note_sum > {1'b0, ACT_MAX}) ? ACT_MAX : note_sum[ACT_W-1:0];

  assign act_new  = act_prod_r[16 +: ACT_W];
  assign lvl_prod = {act_new, 8'b0} - {8'b0, act_new};

  // the sum only exceeds 64 bits with very wide counters
  assign ovf   = (sum_r >> TOT_W) != '0;
  assign total = ovf ? sum4_r[TOT_W-1:0] : sum_r[TOT_W-1:0];

  assign div_cnt   = ovf_r ? (ent_cnt >> 4) : ent_cnt;
  assign div_start = (state_r == S_MUL);
  assign out_load  = (state_r == S_EMIT) && (!out_valid || out_ready);

  always_comb begin
    mem_raddr = (state_r == S_IDLE) ? note_class(in_midi_note) : cls_r;
    mem_we    = 1'b0;
    mem_waddr = cls_r;
    mem_wdata = {cnt_keep_r, act_new};
    if (state_r == S_NOTE) begin
      mem_we    = 1'b1;
      mem_waddr = pc_r;
      mem_wdata = {note_cnt, note_act};
    end else if (state_r == S_DIV && wb_pend_r) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    mem_q_r  <= mem_r[mem_raddr];
    mem_qv_r <= vld_r[mem_raddr];
    if (mem_we) mem_r[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[mem_waddr] <= 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_xfer) state_nxt = in_op ? S_SUM : S_NOTE;
      S_NOTE: state_nxt = S_IDLE;
      S_SUM:  if (cls_r == LAST_CLS) state_nxt = S_PREP;
      S_PREP: if (f_done_r && !sum_tag_r) state_nxt = S_RD;
      S_RD:   state_nxt = S_MUL;
      S_MUL:  state_nxt = S_DIV;
      S_DIV:  if (div_done) state_nxt = S_EMIT;
      S_EMIT: if (out_load) state_nxt = (cls_r == LAST_CLS) ? S_IDLE : S_RD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cls_r        <= '0;
      interval_r   <= INTERVAL_RST;
      seen_r       <= 1'b0;
      last_decay_r <= '0;
      last_upd_r   <= '0;
      elapsed_r    <= 1'b0;
      hist_valid_r <= 1'b0;
      ovf_r        <= 1'b0;
      sum_tag_r    <= 1'b0;
      wb_pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      sum_tag_r <= (state_r == S_SUM);
      if (cfg_wr_en) interval_r <= cfg_wr_data;

      if (in_xfer && in_op) begin
        seen_r       <= 1'b1;
        last_decay_r <= in_now_ms;
        cls_r        <= '0;
        elapsed_r    <= (in_now_ms - last_upd_r) >= {16'b0, interval_r};
        if ((in_now_ms - last_upd_r) >= {16'b0, interval_r}) last_upd_r <= in_now_ms;
      end

      case (state_r)
        S_SUM: begin
          if (cls_r == LAST_CLS) cls_r <= '0;
          else cls_r <= cls_r + 1'b1;
        end
        S_PREP: begin
          ovf_r        <= ovf;
          hist_valid_r <= elapsed_r && (total != '0);
        end
        S_MUL:  wb_pend_r <= 1'b1;
        S_DIV:  wb_pend_r <= 1'b0;
        S_EMIT: if (out_load && cls_r != LAST_CLS) cls_r <= cls_r + 1'b1;
        default: ;
      endcase
    end
  end

  // payload side of the datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pc_r   <= note_class(in_midi_note);
      vel_r  <= in_velocity;
      sum_r  <= '0;
      sum4_r <= '0;
    end
    if (sum_tag_r) begin
      sum_r  <= sum_r + SUM_W'(ent_cnt);
      sum4_r <= sum4_r + SUM_W'(ent_cnt >> 4);
    end
    if (state_r == S_PREP) total_r <= total;
    if (state_r == S_MUL) begin
      cnt_keep_r <= ent_cnt;
      act_prod_r <= (ACT_W+F_W)'(ent_act) * (ACT_W+F_W)'(f_r);
    end
    if (state_r == S_DIV && wb_pend_r) begin
      lvl_r <= (lvl_prod[ACT_W+7:26] > 9'd255) ? 8'd255 : lvl_prod[33:26];
    end
  end

  // decay factor: product of the squared powers for the set bits of dt
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_busy_r <= 1'b0;
      fs_ph_r   <= FP_MUL;
      f_done_r  <= 1'b0;
    end else if (in_xfer && in_op) begin
      fs_ph_r <= FP_MUL;
      if (!seen_r) begin
        f_done_r  <= 1'b1;
        fs_busy_r <= 1'b0;
      end else if (dt >= DT_LIMIT) begin
        f_done_r  <= 1'b1;
        fs_busy_r <= 1'b0;
      end else begin
        f_done_r  <= 1'b0;
        fs_busy_r <= 1'b1;
      end
    end else if (fs_busy_r) begin
      case (fs_ph_r)
        FP_MUL: fs_ph_r <= FP_RND;
        FP_RND: fs_ph_r <= (fb_r == LAST_DT_BIT) ? FP_FIN : FP_MUL;
        FP_FIN: begin
          fs_busy_r <= 1'b0;
          f_done_r  <= 1'b1;
        end
        default: fs_ph_r <= FP_MUL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_op) begin
      fb_r  <= '0;
      dt_r  <= dt[DT_BITS-1:0];
      acc_r <= 33'h1_0000_0000;
      pw_r  <= DECAY_BASE;
      if (!seen_r) f_r <= F_ONE;
      else if (dt >= DT_LIMIT) f_r <= '0;
    end else if (fs_busy_r) begin
      case (fs_ph_r)
        FP_MUL: begin
          pa_r <= 65'(acc_r) * 65'(pw_r);
          pp_r <= 64'(pw_r) * 64'(pw_r);
        end
        FP_RND: begin
          if (dt_r[fb_r]) acc_r <= 33'((pa_r + 65'(HALF_Q32)) >> 32);
          pw_r <= 32'((pp_r + 64'(HALF_Q32)) >> 32);
          fb_r <= fb_r + 1'b1;
        end
        FP_FIN: f_r <= F_W'((acc_r + 33'(HALF_Q16)) >> 16);
        default: ;
      endcase
    end
  end

  pcat_share_div #(
    .W (TOT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (TOT_W'(div_cnt)),
    .den   (total_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  logic [CLS_W-1:0]   out_cls_r;
  logic [LVL_W-1:0]   out_lvl_r;
  logic [SHARE_W-1:0] out_share_r;
  logic               out_hv_r;
  logic               out_last_r;

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cls_r   <= cls_r;
      out_lvl_r   <= lvl_r;
      out_share_r <= hist_valid_r ? div_quo : '0;
      out_hv_r    <= hist_valid_r;
      out_last_r  <= (cls_r == LAST_CLS);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pitch_class    = out_cls_r;
  assign out_activity_level = out_lvl_r;
  assign out_hist_share     = out_share_r;
  assign out_hist_valid     = out_hv_r;
  assign out_last           = out_last_r;

endmodule

[rtl/pcat_checker.sv]
`timescale 1ns / 1ps
// port-level checks for the pitch class activity tracker, bound to the top level
// depends on pitch_class_activity_tracker

module pcat_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_op,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_pitch_class,
  input logic [7:0]  out_activity_level,
  input logic [15:0] out_hist_share,
  input logic        out_hist_valid,
  input logic        out_last
);

  // last marks exactly the final class of a tick
  a_last_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_pitch_class == 4'd11)))
    else $error("out_last does not match class 11");

  a_share_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hist_valid |-> out_hist_share == 16'd0)
    else $error("share nonzero while hist_valid is low");

  // a note event never raises a result
  a_note_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_op && !out_valid |=> !out_valid)
    else $error("result appeared after a note transfer");

  // while a result other than the last waits, the tick is still in progress
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready in the middle of a tick");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pitch_class)
      && $stable(out_activity_level) && $stable(out_hist_share)
      && $stable(out_hist_valid) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind pitch_class_activity_tracker pcat_checker u_pcat_checker (.*);
